// File: rtl/assert_macros.svh
// Assertion macros shared by the speed PID block.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/msp_pkg.sv
// Types and fixed constants of the motor speed PID block.
// No dependencies; imported by every module of the block.
package msp_pkg;

   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int SCALE_W  = 20;
   localparam int SPEED_W  = 16;
   localparam int RAW_W    = 16;
   localparam int COUNT_W  = 14;
   localparam int DELTA_W  = 16;
   localparam int INTEG_W  = 48;
   localparam int DRIVE_W  = 16;
   localparam int TARGET_W = 32;
   localparam int DUTY_W   = 15;
   localparam int DVS_W    = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // rpm to pulses per frame: revolutions per minute over milliseconds per minute
   localparam logic [DVS_W-1:0] RPM_DIVISOR = 16'd60000;

   localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd20;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd12;
   localparam logic [GAIN_W-1:0]  GAIN_DIVISOR_RST = 16'd50;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd1000;
   localparam logic [LIMIT_W-1:0] DUTY_FLOOR_RST  = 15'd0;
   localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 15'd1000;
   localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 20'd5;

   typedef enum logic [2:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_GAIN_DIVISOR,
      CSR_DRIVE_LIMIT,
      CSR_DUTY_FLOOR,
      CSR_SPEED_LIMIT,
      CSR_SPEED_SCALE
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_SPEED,
      OP_TICK
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLAMP,
      S_SPD_MUL,
      S_SPD_DIV,
      S_SPD_WAIT,
      S_TARGET,
      S_DIFF,
      S_MUL,
      S_SUM,
      S_TCK_DIV,
      S_TCK_WAIT,
      S_DRIVE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [GAIN_W-1:0]  gain_divisor;
      logic [LIMIT_W-1:0] drive_limit;
      logic [LIMIT_W-1:0] duty_floor;
      logic [LIMIT_W-1:0] speed_limit;
      logic [SCALE_W-1:0] speed_scale;
   } msp_cfg_type;

   typedef struct packed {
      logic capture;
      logic clamp_load;
      logic clear_loop;
      logic spd_mul;
      logic tick_diff;
      logic tick_mul;
      logic tick_sum;
      logic div_start;
      logic div_tick;
      logic target_load;
      logic drive_load;
      logic emit_load;
   } msp_cmd_type;

   typedef struct packed {
      logic moving;
      logic speed_zero;
      logic div_busy;
   } msp_sts_type;

endpackage

// File: rtl/msp_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on msp_pkg; used by msp_datapath.
module msp_div
   import msp_pkg::*;
#(
   parameter int DVD_W = 44
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEPS = DVD_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DVS_W-1:0]       rem_ff, rem_in;
   logic [DVD_W-1:0]       quo_ff, quo_in;
   logic [DVS_W-1:0]       dvs_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;
   logic [DVS_W+DVD_W-1:0] step_one, step_two;

   // One restoring step: shift in the next dividend bit, subtract when it fits
   function automatic logic [DVS_W+DVD_W-1:0] div_step(
      input logic [DVS_W-1:0] rem,
      input logic [DVD_W-1:0] quo,
      input logic [DVS_W-1:0] dvs
   );
      logic [DVS_W:0]   shifted;
      logic [DVS_W+1:0] trial;
      logic [DVS_W-1:0] rem_out;
      logic             qbit;
      shifted = {rem, quo[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs};
      qbit    = ~trial[DVS_W+1];
      rem_out = qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      return {rem_out, quo[DVD_W-2:0], qbit};
   endfunction

   // Two chained steps per cycle
   always_comb begin
      step_one = div_step(rem_ff, quo_ff, dvs_ff);
      step_two = div_step(step_one[DVS_W+DVD_W-1:DVD_W], step_one[DVD_W-1:0], dvs_ff);
      rem_in   = step_two[DVS_W+DVD_W-1:DVD_W];
      quo_in   = step_two[DVD_W-1:0];
   end

   // Load operands on start, advance while busy
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(STEPS);
      end else if (busy_ff) begin
         busy_ff <= (cnt_ff != CNT_W'(1));
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/msp_datapath.sv
// Datapath of the speed PID: loop state, multipliers, divider and result registers.
// Depends on msp_pkg and msp_div; driven by commands from msp_ctrl.
module msp_datapath
   import msp_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  msp_cfg_type               cfg,
   input  msp_cmd_type               cmd,
   output msp_sts_type               sts,
   input  logic signed [SPEED_W-1:0] req_speed_rpm,
   input  logic [RAW_W-1:0]          req_encoder_raw,
   output logic signed [DRIVE_W-1:0] rsp_drive_value,
   output logic [DUTY_W-1:0]         rsp_duty,
   output logic                      rsp_reverse,
   output logic                      rsp_running
);

   // Widths that follow from the fraction length
   localparam int DSH_W   = (COUNT_W + 1) + FRAC_BITS;
   localparam int ERR_W   = ((DSH_W > TARGET_W) ? DSH_W : TARGET_W) + 1;
   localparam int DD_W    = DELTA_W + 1;
   localparam int PP_W    = ERR_W + GAIN_W + 1;
   localparam int DP_W    = DD_W + GAIN_W + 1;
   localparam int DPS_W   = DP_W + FRAC_BITS;
   localparam int SUM_A   = (PP_W > DPS_W) ? PP_W : DPS_W;
   localparam int SUM_W   = ((SUM_A > INTEG_W) ? SUM_A : INTEG_W) + 2;
   localparam int IS_W    = ((PP_W > INTEG_W) ? PP_W : INTEG_W) + 1;
   localparam int SPR_W   = LIMIT_W + SCALE_W;
   localparam int DVD_A   = ((SUM_W - FRAC_BITS) > (SPR_W + FRAC_BITS))
                            ? (SUM_W - FRAC_BITS) : (SPR_W + FRAC_BITS);
   localparam int DVD_W   = DVD_A + (DVD_A % 2);

   localparam logic [DVD_W-1:0] TGT_POS_MAG = DVD_W'({1'b0, {(TARGET_W-1){1'b1}}});
   localparam logic [DVD_W-1:0] TGT_NEG_MAG = DVD_W'({1'b1, {(TARGET_W-1){1'b0}}});
   localparam logic [DVD_W-1:0] DRV_POS_MAG = DVD_W'({1'b0, {(DRIVE_W-1){1'b1}}});
   localparam logic [DVD_W-1:0] DRV_NEG_MAG = DVD_W'({1'b1, {(DRIVE_W-1){1'b0}}});
   localparam logic signed [IS_W-1:0] INT_MAX =
      IS_W'($signed({1'b0, {(INTEG_W-1){1'b1}}}));
   localparam logic signed [IS_W-1:0] INT_MIN =
      IS_W'($signed({1'b1, {(INTEG_W-1){1'b0}}}));

   // Captured request
   logic signed [SPEED_W-1:0]  speed_ff;
   logic [RAW_W-1:0]           raw_ff;

   // Speed command path
   logic                       spd_neg_ff;
   logic [LIMIT_W-1:0]         spd_mag_ff;
   logic [SPR_W-1:0]           spd_prod_ff;
   logic signed [SPEED_W:0]    spd_wide, lim_pos, lim_neg, spd_clamp, spd_abs;

   // Tick path
   logic signed [COUNT_W:0]    delta_ff, delta_in;
   logic signed [DD_W-1:0]     dd_ff;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [PP_W-1:0]     pp_ff, ip_ff;
   logic signed [DP_W-1:0]     dp_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic                       sum_neg_ff;
   logic [SUM_W-1:0]           sum_mag_ff;
   logic signed [IS_W-1:0]     isum;
   logic signed [INTEG_W-1:0]  integral_in;

   // Loop state
   logic [COUNT_W-1:0]         last_count_ff;
   logic signed [DELTA_W-1:0]  last_delta_ff;
   logic signed [INTEG_W-1:0]  integral_ff;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic signed [TARGET_W-1:0] target_ff, target_in;
   logic                       moving_ff;

   // Divider hookup
   logic [DVD_W-1:0]           div_dividend, div_quo;
   logic [DVS_W-1:0]           div_divisor;
   logic                       div_busy;

   // Drive update
   logic signed [DRIVE_W:0]    q_sat;
   logic signed [DRIVE_W+1:0]  nd_wide, dlim_pos, dlim_neg;

   // Result formatting
   logic signed [DRIVE_W-1:0]  drv_abs;
   logic [DUTY_W-1:0]          duty_in;

   logic signed [DRIVE_W-1:0]  rsp_drive_ff;
   logic [DUTY_W-1:0]          rsp_duty_ff;
   logic                       rsp_reverse_ff, rsp_running_ff;

   // Hold the request fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         speed_ff <= req_speed_rpm;
         raw_ff   <= req_encoder_raw;
      end
   end

   // Clamp the command to the speed limit
   always_comb begin
      spd_wide = (SPEED_W+1)'(speed_ff);
      lim_pos  = $signed({2'b00, cfg.speed_limit});
      lim_neg  = -lim_pos;
      if (spd_wide > lim_pos) begin
         spd_clamp = lim_pos;
      end else if (spd_wide < lim_neg) begin
         spd_clamp = lim_neg;
      end else begin
         spd_clamp = spd_wide;
      end
      spd_abs = spd_clamp[SPEED_W] ? -spd_clamp : spd_clamp;
   end

   always_ff @(posedge clock) begin
      if (cmd.clamp_load) begin
         spd_neg_ff <= spd_clamp[SPEED_W];
         spd_mag_ff <= spd_abs[LIMIT_W-1:0];
      end
      if (cmd.spd_mul) begin
         spd_prod_ff <= SPR_W'(spd_mag_ff) * SPR_W'(cfg.speed_scale);
      end
   end

   // Pulse delta and error
   always_comb begin
      delta_in = $signed({1'b0, raw_ff[RAW_W-1:RAW_W-COUNT_W]})
               - $signed({1'b0, last_count_ff});
      err_in   = ERR_W'(target_ff) - (ERR_W'(delta_in) <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_diff) begin
         delta_ff <= delta_in;
         err_ff   <= err_in;
         dd_ff    <= DD_W'(delta_in) - DD_W'(last_delta_ff);
      end
      if (cmd.tick_mul) begin
         pp_ff <= $signed({1'b0, cfg.gain_p}) * err_ff;
         ip_ff <= $signed({1'b0, cfg.gain_i}) * err_ff;
         dp_ff <= $signed({1'b0, cfg.gain_d}) * dd_ff;
      end
   end

   // PID sum and saturated integral
   always_comb begin
      sum_in = SUM_W'(pp_ff) - (SUM_W'(dp_ff) <<< FRAC_BITS) + SUM_W'(integral_ff);
      isum   = IS_W'(integral_ff) + IS_W'(ip_ff);
      if (isum > INT_MAX) begin
         integral_in = INT_MAX[INTEG_W-1:0];
      end else if (isum < INT_MIN) begin
         integral_in = INT_MIN[INTEG_W-1:0];
      end else begin
         integral_in = isum[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_sum) begin
         sum_neg_ff <= sum_in[SUM_W-1];
         sum_mag_ff <= sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      end
   end

   // Divider operands: PID sum over divisor, or scaled speed over rpm constant
   always_comb begin
      if (cmd.div_tick) begin
         div_dividend = DVD_W'(sum_mag_ff >> FRAC_BITS);
         div_divisor  = (cfg.gain_divisor == '0) ? DVS_W'(1) : cfg.gain_divisor;
      end else begin
         div_dividend = DVD_W'(spd_prod_ff) << FRAC_BITS;
         div_divisor  = RPM_DIVISOR;
      end
   end

   msp_div #(
      .DVD_W (DVD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Saturate the target to 32 bits
   always_comb begin
      if (spd_neg_ff) begin
         target_in = (div_quo > TGT_NEG_MAG) ? $signed(TGT_NEG_MAG[TARGET_W-1:0])
                                             : -$signed(div_quo[TARGET_W-1:0]);
      end else begin
         target_in = (div_quo > TGT_POS_MAG) ? $signed(TGT_POS_MAG[TARGET_W-1:0])
                                             : $signed(div_quo[TARGET_W-1:0]);
      end
   end

   // Saturate the quotient, add to the drive and clamp to the drive limit
   always_comb begin
      if (sum_neg_ff) begin
         q_sat = (div_quo > DRV_NEG_MAG) ? -$signed(DRV_NEG_MAG[DRIVE_W:0])
                                         : -$signed(div_quo[DRIVE_W:0]);
      end else begin
         q_sat = (div_quo > DRV_POS_MAG) ? $signed(DRV_POS_MAG[DRIVE_W:0])
                                         : $signed(div_quo[DRIVE_W:0]);
      end
      nd_wide  = (DRIVE_W+2)'(q_sat) + (DRIVE_W+2)'(drive_ff);
      dlim_pos = $signed({3'b000, cfg.drive_limit});
      dlim_neg = -dlim_pos;
      if (nd_wide > dlim_pos) begin
         drive_in = dlim_pos[DRIVE_W-1:0];
      end else if (nd_wide < dlim_neg) begin
         drive_in = dlim_neg[DRIVE_W-1:0];
      end else begin
         drive_in = nd_wide[DRIVE_W-1:0];
      end
   end

   // Loop state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         last_delta_ff <= '0;
         integral_ff   <= '0;
         drive_ff      <= '0;
         target_ff     <= '0;
         moving_ff     <= 1'b0;
      end else if (cmd.clear_loop) begin
         last_count_ff <= raw_ff[RAW_W-1:RAW_W-COUNT_W];
         last_delta_ff <= '0;
         integral_ff   <= '0;
         drive_ff      <= '0;
         target_ff     <= '0;
         moving_ff     <= 1'b0;
      end else begin
         if (cmd.tick_sum) begin
            last_count_ff <= raw_ff[RAW_W-1:RAW_W-COUNT_W];
            last_delta_ff <= DELTA_W'(delta_ff);
            integral_ff   <= integral_in;
         end
         if (cmd.target_load) begin
            target_ff <= target_in;
            moving_ff <= 1'b1;
         end
         if (cmd.drive_load) begin
            drive_ff <= drive_in;
         end
      end
   end

   // Duty is the drive magnitude raised to the duty floor
   always_comb begin
      drv_abs = drive_ff[DRIVE_W-1] ? -drive_ff : drive_ff;
      duty_in = (drv_abs[DUTY_W-1:0] < cfg.duty_floor) ? cfg.duty_floor
                                                        : drv_abs[DUTY_W-1:0];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_drive_ff   <= moving_ff ? drive_ff : '0;
         rsp_duty_ff    <= moving_ff ? duty_in : '0;
         rsp_reverse_ff <= moving_ff & drive_ff[DRIVE_W-1];
         rsp_running_ff <= moving_ff;
      end
   end

   assign rsp_drive_value = rsp_drive_ff;
   assign rsp_duty        = rsp_duty_ff;
   assign rsp_reverse     = rsp_reverse_ff;
   assign rsp_running     = rsp_running_ff;

   assign sts.moving     = moving_ff;
   assign sts.speed_zero = (spd_clamp == '0);
   assign sts.div_busy   = div_busy;

endmodule

// File: rtl/msp_ctrl.sv
// Sequencer of the speed PID: steps one request through the datapath.
// Depends on msp_pkg and assert_macros.svh; drives msp_datapath by command.
`include "assert_macros.svh"
module msp_ctrl
   import msp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_opcode,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  msp_sts_type sts,
   output msp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (opcode_type'(req_opcode) == OP_SPEED) begin
                  state_in = S_CLAMP;
               end else if (sts.moving) begin
                  state_in = S_DIFF;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_CLAMP: begin
            cmd.clamp_load = 1'b1;
            if (sts.speed_zero) begin
               cmd.clear_loop = 1'b1;
               state_in       = S_EMIT;
            end else begin
               state_in = S_SPD_MUL;
            end
         end
         S_SPD_MUL: begin
            cmd.spd_mul = 1'b1;
            state_in    = S_SPD_DIV;
         end
         S_SPD_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_SPD_WAIT;
         end
         S_SPD_WAIT: begin
            if (!sts.div_busy) begin
               state_in = S_TARGET;
            end
         end
         S_TARGET: begin
            cmd.target_load = 1'b1;
            state_in        = S_EMIT;
         end
         S_DIFF: begin
            cmd.tick_diff = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.tick_mul = 1'b1;
            state_in     = S_SUM;
         end
         S_SUM: begin
            cmd.tick_sum = 1'b1;
            state_in     = S_TCK_DIV;
         end
         S_TCK_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_tick  = 1'b1;
            state_in      = S_TCK_WAIT;
         end
         S_TCK_WAIT: begin
            cmd.div_tick = 1'b1;
            if (!sts.div_busy) begin
               state_in = S_DRIVE;
            end
         end
         S_DRIVE: begin
            cmd.div_tick   = 1'b1;
            cmd.drive_load = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `MSP_ASSERT_IMP(a_div_start_free, clock, reset, cmd.div_start, !sts.div_busy,
      "divider started while still busy")
   `MSP_ASSERT_NXT(a_div_takes_start, clock, reset, cmd.div_start, sts.div_busy,
      "divider did not pick up its operands")
   `MSP_ASSERT_NXT(a_emit_shows, clock, reset, cmd.emit_load,
      rsp_valid_ff && state_ff == S_IDLE, "loaded result not presented")

endmodule

// File: rtl/motor_speed_pid.sv
// Motor speed PID, incremental form with derivative on measurement.
// A tick while stopped and a stop skip the divider; a run command and a live tick wait on
// the shared divider, which retires two quotient bits a cycle (22 iterations at FRAC_BITS 8).
// One request is in flight at a time; the next is taken the cycle after the result loads.
// Reset is synchronous and active high: loop state clears, registers reload defaults.
module motor_speed_pid
   import msp_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic signed [SPEED_W-1:0] req_speed_rpm,
   input  logic [RAW_W-1:0]          req_encoder_raw,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_drive_value,
   output logic [DUTY_W-1:0]         rsp_duty,
   output logic                      rsp_reverse,
   output logic                      rsp_running,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   msp_cfg_type   cfg_ff;
   msp_cmd_type   cmd;
   msp_sts_type   sts;
   csr_index_type csr_index;
   logic          csr_write;

   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p       <= GAIN_P_RST;
         cfg_ff.gain_i       <= GAIN_I_RST;
         cfg_ff.gain_d       <= GAIN_D_RST;
         cfg_ff.gain_divisor <= GAIN_DIVISOR_RST;
         cfg_ff.drive_limit  <= DRIVE_LIMIT_RST;
         cfg_ff.duty_floor   <= DUTY_FLOOR_RST;
         cfg_ff.speed_limit  <= SPEED_LIMIT_RST;
         cfg_ff.speed_scale  <= SPEED_SCALE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_P:       cfg_ff.gain_p       <= pwdata[GAIN_W-1:0];
            CSR_GAIN_I:       cfg_ff.gain_i       <= pwdata[GAIN_W-1:0];
            CSR_GAIN_D:       cfg_ff.gain_d       <= pwdata[GAIN_W-1:0];
            CSR_GAIN_DIVISOR: cfg_ff.gain_divisor <= pwdata[GAIN_W-1:0];
            CSR_DRIVE_LIMIT:  cfg_ff.drive_limit  <= pwdata[LIMIT_W-1:0];
            CSR_DUTY_FLOOR:   cfg_ff.duty_floor   <= pwdata[LIMIT_W-1:0];
            CSR_SPEED_LIMIT:  cfg_ff.speed_limit  <= pwdata[LIMIT_W-1:0];
            CSR_SPEED_SCALE:  cfg_ff.speed_scale  <= pwdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_index)
         CSR_GAIN_P:       prdata = CSR_DATA_W'(cfg_ff.gain_p);
         CSR_GAIN_I:       prdata = CSR_DATA_W'(cfg_ff.gain_i);
         CSR_GAIN_D:       prdata = CSR_DATA_W'(cfg_ff.gain_d);
         CSR_GAIN_DIVISOR: prdata = CSR_DATA_W'(cfg_ff.gain_divisor);
         CSR_DRIVE_LIMIT:  prdata = CSR_DATA_W'(cfg_ff.drive_limit);
         CSR_DUTY_FLOOR:   prdata = CSR_DATA_W'(cfg_ff.duty_floor);
         CSR_SPEED_LIMIT:  prdata = CSR_DATA_W'(cfg_ff.speed_limit);
         CSR_SPEED_SCALE:  prdata = CSR_DATA_W'(cfg_ff.speed_scale);
         default:          prdata = '0;
      endcase
   end

   msp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   msp_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .sts             (sts),
      .req_speed_rpm   (req_speed_rpm),
      .req_encoder_raw (req_encoder_raw),
      .rsp_drive_value (rsp_drive_value),
      .rsp_duty        (rsp_duty),
      .rsp_reverse     (rsp_reverse),
      .rsp_running     (rsp_running)
   );

endmodule

// File: test/motor_speed_pid_tb.sv
// Self-checking bench for motor_speed_pid: a queue-fed request driver, a stalling result
// monitor and a cycle-free predictor of the incremental speed loop, plus APB register traffic.
// Depends on msp_pkg and the motor_speed_pid RTL only.
module motor_speed_pid_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import msp_pkg::*;

   localparam int     HALF_PERIOD = 6;
   localparam int     FRAC_BITS   = 8;
   localparam int     NUM_CSR     = 8;
   localparam int     DRAIN_WAIT  = 40;
   localparam int     LONG_HOLD   = 300;
   localparam longint ONE         = longint'(1) << FRAC_BITS;
   localparam longint INTEG_MAX   = (longint'(1) << (INTEG_W - 1)) - 1;
   localparam longint INTEG_MIN   = -INTEG_MAX - 1;
   localparam longint TGT_MAX     = (longint'(1) << (TARGET_W - 1)) - 1;
   localparam longint TGT_MIN     = -TGT_MAX - 1;
   localparam longint QUO_MAX     = (longint'(1) << (DRIVE_W - 1)) - 1;
   localparam longint QUO_MIN     = -QUO_MAX - 1;

   typedef struct packed {
      opcode_type                op;
      logic signed [SPEED_W-1:0] speed;
      logic [RAW_W-1:0]          raw;
   } speed_req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic [DUTY_W-1:0]         duty;
      logic                      reverse;
      logic                      running;
   } drive_out_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_PATTERN,
      STALL_RANDOM
   } stall_kind_type;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic                      req_opcode      = 1'b0;
   logic signed [SPEED_W-1:0] req_speed_rpm   = '0;
   logic [RAW_W-1:0]          req_encoder_raw = '0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive_value;
   logic [DUTY_W-1:0]         rsp_duty;
   logic                      rsp_reverse;
   logic                      rsp_running;
   logic                      psel            = 1'b0;
   logic                      penable         = 1'b0;
   logic                      pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr           = '0;
   logic [CSR_DATA_W-1:0]     pwdata          = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;

   // register shadow, updated as each write lands
   logic [CSR_DATA_W-1:0] reg_shadow [NUM_CSR];

   // loop state of the predictor
   logic [COUNT_W-1:0] pid_last_count;
   longint             pid_last_delta;
   longint             pid_integral;
   longint             pid_drive;
   longint             pid_target;
   bit                 pid_moving;

   speed_req_type  pending_reqs [$];
   drive_out_type  expected_outs [$];
   speed_req_type  next_req;
   speed_req_type  taken_req;
   drive_out_type  want_out;

   int             burst_left;
   int             gap_left;
   int             reqs_accepted = 0;
   int             loop_ticks    = 0;
   int             outs_checked  = 0;
   int             rsp_errors    = 0;
   int             csr_errors    = 0;
   int             settings_run  = 0;
   stall_kind_type stall_mode;
   int             mode_cycles;
   int             hold_left;
   bit             hold_done;
   logic [15:0]    stall_pat;

   motor_speed_pid #(.FRAC_BITS(FRAC_BITS)) u_top (.*);

   always #(HALF_PERIOD) clock = ~clock;

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] csr_mask(csr_index_type idx);
      case (idx)
         CSR_DRIVE_LIMIT, CSR_DUTY_FLOOR, CSR_SPEED_LIMIT: return (32'd1 << LIMIT_W) - 32'd1;
         CSR_SPEED_SCALE: return (32'd1 << SCALE_W) - 32'd1;
         default: return (32'd1 << GAIN_W) - 32'd1;
      endcase
   endfunction

   // Advance the loop by one request and return the result it should produce
   function automatic drive_out_type advance_controller(speed_req_type rq);
      longint        spd;
      longint        lim;
      longint        cur;
      longint        delta;
      longint        err;
      longint        dmeas;
      longint        total;
      longint        dvsr;
      longint        quo;
      longint        mag;
      drive_out_type o;
      if (rq.op == OP_SPEED) begin
         spd = longint'($signed(rq.speed));
         lim = longint'(reg_shadow[CSR_SPEED_LIMIT]);
         if (spd > lim) spd = lim;
         else if (spd < -lim) spd = -lim;
         if (spd == 0) begin
            // brake: keep the encoder position, drop everything else
            pid_moving     = 1'b0;
            pid_last_count = rq.raw[RAW_W-1:2];
            pid_last_delta = 0;
            pid_integral   = 0;
            pid_drive      = 0;
            pid_target     = 0;
         end else begin
            total      = spd * longint'(reg_shadow[CSR_SPEED_SCALE]) * ONE
                         / longint'(RPM_DIVISOR);
            pid_target = clip(total, TGT_MIN, TGT_MAX);
            pid_moving = 1'b1;
         end
      end else if (pid_moving) begin
         cur   = longint'(rq.raw[RAW_W-1:2]);
         delta = cur - longint'(pid_last_count);
         err   = pid_target - delta * ONE;
         dmeas = (delta - pid_last_delta) * ONE;
         total = longint'(reg_shadow[CSR_GAIN_P]) * err
                 - longint'(reg_shadow[CSR_GAIN_D]) * dmeas + pid_integral;
         dvsr  = (reg_shadow[CSR_GAIN_DIVISOR] == 0) ? ONE
                 : longint'(reg_shadow[CSR_GAIN_DIVISOR]) * ONE;
         quo   = clip(total / dvsr, QUO_MIN, QUO_MAX);
         lim   = longint'(reg_shadow[CSR_DRIVE_LIMIT]);
         pid_drive      = clip(quo + pid_drive, -lim, lim);
         pid_integral   = clip(pid_integral + longint'(reg_shadow[CSR_GAIN_I]) * err,
                               INTEG_MIN, INTEG_MAX);
         pid_last_count = cur[COUNT_W-1:0];
         pid_last_delta = delta;
      end
      o = '0;
      if (pid_moving) begin
         mag = (pid_drive < 0) ? -pid_drive : pid_drive;
         if (mag < longint'(reg_shadow[CSR_DUTY_FLOOR])) mag = longint'(reg_shadow[CSR_DUTY_FLOOR]);
         o.drive   = pid_drive[DRIVE_W-1:0];
         o.duty    = mag[DUTY_W-1:0];
         o.reverse = (pid_drive < 0);
         o.running = 1'b1;
      end
      return o;
   endfunction

   // Request driver: score what the block takes, then hold, idle or offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         pid_last_count = '0;
         pid_last_delta = 0;
         pid_integral   = 0;
         pid_drive      = 0;
         pid_target     = 0;
         pid_moving     = 1'b0;
         burst_left     = 1;
         gap_left       = 0;
      end else begin
         if (req_valid && !req_stall) begin
            taken_req = '{op: opcode_type'(req_opcode), speed: req_speed_rpm,
                          raw: req_encoder_raw};
            if (taken_req.op == OP_TICK && pid_moving) loop_ticks++;
            expected_outs.push_back(advance_controller(taken_req));
            reqs_accepted++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled request as it is
         end else if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            next_req = pending_reqs.pop_front();
            req_valid       <= 1'b1;
            req_opcode      <= next_req.op;
            req_speed_rpm   <= next_req.speed;
            req_encoder_raw <= next_req.raw;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end
      end
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         rsp_errors++;
      end
   endtask

   // Result monitor: check the accepted result, then choose the stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_mode  = STALL_NONE;
         mode_cycles = 0;
         hold_left   = 0;
         hold_done   = 1'b0;
         stall_pat   = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outs.size() == 0) begin
               $display("%0t: result with no request pending, expected none, got drive %0d",
                        $time, rsp_drive_value);
               rsp_errors++;
            end else begin
               want_out = expected_outs.pop_front();
               check_field("drive_value", $signed(want_out.drive), $signed(rsp_drive_value));
               check_field("duty", want_out.duty, rsp_duty);
               check_field("reverse", want_out.reverse, rsp_reverse);
               check_field("running", want_out.running, rsp_running);
            end
            outs_checked++;
         end
         mode_cycles++;
         if (mode_cycles >= 64) begin
            mode_cycles = 0;
            stall_mode  = stall_kind_type'($urandom_range(0, 2));
            stall_pat   = 16'($urandom);
         end
         // one long hold-off so the block backs up onto its request side
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && outs_checked >= 500) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:    rsp_stall <= 1'b0;
               STALL_PATTERN: rsp_stall <= stall_pat[mode_cycles % 16];
               default:       rsp_stall <= ($urandom_range(0, 2) == 0);
            endcase
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // the register takes the value at this edge
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      reg_shadow[idx] = value & csr_mask(idx);
   endtask

   task automatic csr_read(csr_index_type idx);
      logic [CSR_DATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== reg_shadow[idx]) begin
         $display("%0t: register %s readback, expected %0d, got %0d", $time, idx.name(),
                  reg_shadow[idx], got);
         csr_errors++;
      end
   endtask

   task automatic queue_req(opcode_type op, int speed, int raw);
      speed_req_type r;
      r.op    = op;
      r.speed = SPEED_W'(speed);
      r.raw   = RAW_W'(raw);
      pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_outs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_setting(csr_index_type idx);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return csr_mask(idx);
         2, 3, 4, 5: return CSR_DATA_W'($urandom_range(1, 2000));
         default: return $urandom & csr_mask(idx);
      endcase
   endfunction

   // A run command followed mostly by smooth encoder motion, with more run commands, stops and encoder jumps
   task automatic queue_phase(int n);
      speed_req_type             r;
      logic [RAW_W-1:0]          enc;
      logic signed [SPEED_W-1:0] spd;
      int                        counted;
      int                        tries;
      int                        pick;
      int                        kind;
      enc         = RAW_W'($urandom);
      counted     = 0;
      tries       = 0;
      while (counted < n && tries < 4 * n) begin
         tries++;
         pick = $urandom_range(0, 99);
         if (tries == 1 || pick < 8) begin
            kind = (tries == 1) ? 2 : $urandom_range(0, 4);
            case (kind)
               0: spd = '0;
               1: spd = SPEED_W'($urandom);
               2: spd = SPEED_W'($urandom_range(1, 3000));
               3: spd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               default: spd = SPEED_W'($urandom_range(1, reg_shadow[CSR_SPEED_LIMIT] + 1));
            endcase
            if ((kind == 2 || kind == 4) && $urandom_range(0, 1) == 1) spd = -spd;
            r.op        = OP_SPEED;
            counted++;
         end else begin
            // jump the encoder anywhere now and then, else move it a little
            if (pick < 11) enc = RAW_W'($urandom);
            else enc = enc + RAW_W'($urandom_range(0, 2048)) - RAW_W'(1024);
            spd  = SPEED_W'($urandom);
            r.op = OP_TICK;
            counted++;
         end
         r.speed = spd;
         r.raw   = enc;
         pending_reqs.push_back(r);
      end
   endtask

   // Stimulus and verdict
   initial begin
      reg_shadow[CSR_GAIN_P]       = CSR_DATA_W'(GAIN_P_RST);
      reg_shadow[CSR_GAIN_I]       = CSR_DATA_W'(GAIN_I_RST);
      reg_shadow[CSR_GAIN_D]       = CSR_DATA_W'(GAIN_D_RST);
      reg_shadow[CSR_GAIN_DIVISOR] = CSR_DATA_W'(GAIN_DIVISOR_RST);
      reg_shadow[CSR_DRIVE_LIMIT]  = CSR_DATA_W'(DRIVE_LIMIT_RST);
      reg_shadow[CSR_DUTY_FLOOR]   = CSR_DATA_W'(DUTY_FLOOR_RST);
      reg_shadow[CSR_SPEED_LIMIT]  = CSR_DATA_W'(SPEED_LIMIT_RST);
      reg_shadow[CSR_SPEED_SCALE]  = CSR_DATA_W'(SPEED_SCALE_RST);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_CSR; i++) csr_read(csr_index_type'(i));

      // defaults: tick while stopped, stop, clamped run commands both ways, big encoder steps
      queue_req(OP_TICK, 0, 'hFFFF);
      queue_req(OP_SPEED, 0, 'h1234);
      queue_req(OP_SPEED, 32767, 'h0000);
      queue_req(OP_TICK, -1, 'hFFFF);
      queue_req(OP_TICK, 0, 'h8000);
      queue_req(OP_SPEED, -32768, 'h8000);
      queue_req(OP_TICK, 32767, 'h0000);
      queue_req(OP_SPEED, 1, 'h0003);
      queue_req(OP_TICK, 0, 'h5555);
      queue_req(OP_SPEED, 0, 'hFFFF);
      queue_req(OP_TICK, 0, 'hAAAA);
      wait_idle();
      settings_run++;

      // extremes: zero divisor, saturating quotient and integral, duty floor at or above any drive
      for (int i = 0; i < NUM_CSR; i++)
         csr_write(csr_index_type'(i), (i == CSR_GAIN_DIVISOR) ? '0
                                        : csr_mask(csr_index_type'(i)));
      for (int i = 0; i < NUM_CSR; i++) csr_read(csr_index_type'(i));
      queue_req(OP_SPEED, 32767, 'h0000);
      for (int i = 0; i < 15; i++) queue_req(OP_TICK, 0, (i % 2 == 0) ? 'hFFFF : 'h0000);
      wait_idle();
      settings_run++;

      // random settings, each followed by a stretch of loop traffic
      for (int ph = 0; ph < 12; ph++) begin
         for (int i = 0; i < NUM_CSR; i++) begin
            csr_write(csr_index_type'(i), pick_setting(csr_index_type'(i)));
            csr_read(csr_index_type'(i));
         end
         queue_phase(115);
         wait_idle();
         settings_run++;
      end

      $display("Checked %0d results from %0d requests (%0d live control ticks)",
               outs_checked, reqs_accepted, loop_ticks);
      $display("over %0d register settings, including saturation and zero-divisor cases",
               settings_run);
      if (rsp_errors == 0 && csr_errors == 0) begin
         $display("[motor_speed_pid] OK");
      end else begin
         $display("[motor_speed_pid] ERROR");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #10_000_000;
      $display("[motor_speed_pid] ERROR");
      $finish;
   end

endmodule

// File: motor_speed_pid.f
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_div.sv
rtl/msp_datapath.sv
rtl/msp_ctrl.sv
rtl/motor_speed_pid.sv
test/motor_speed_pid_tb.sv
